>>> rtl/spb_pkg.sv
`default_nettype none

package spb_pkg;

  localparam int unsigned IdW    = 32;
  localparam int unsigned XyW    = 6;
  localparam int unsigned RingW  = 4;
  localparam int unsigned DeltaW = 6;

  localparam logic [RingW-1:0] RingReset = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } search_state_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic           hit;
    logic [IdW-1:0] id;
    logic [XyW-1:0] x;
    logic [XyW-1:0] y;
  } pick_res_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_status_t;

endpackage

`default_nettype wire

>>> rtl/spb_id_ram.sv
`default_nettype none

module spb_id_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AW-1:0]          waddr_i,
  input  wire logic [spb_pkg::IdW-1:0] wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AW-1:0]          raddr_i,
  output      logic [spb_pkg::IdW-1:0] rdata_o
);
  import spb_pkg::*;

  logic [IdW-1:0] mem [DEPTH];
  logic [IdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/spb_search_ctrl.sv
`default_nettype none

module spb_search_ctrl #(
  parameter int unsigned SIDE = 64,
  parameter int unsigned OXW  = 8,
  parameter int unsigned AW   = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [OXW-1:0]           ox_i,
  input  wire logic [OXW-1:0]           oy_i,
  input  wire logic [spb_pkg::RingW-1:0] limit_i,
  output      logic                     rd_en_o,
  output      logic [AW-1:0]            rd_addr_o,
  input  wire logic [spb_pkg::IdW-1:0]   rd_data_i,
  input  wire logic                     res_ready_i,
  output      spb_pkg::ctrl_status_t     status_o,
  output      spb_pkg::pick_res_t        res_o
);
  import spb_pkg::*;

  localparam int unsigned CW = OXW + 4;
  localparam int unsigned XW = $clog2(SIDE);
  localparam int unsigned RW = RingW + 1;

  search_state_e state_q, state_d;

  logic [CW-1:0]            ox_q, ox_d, oy_q, oy_d;
  logic signed [DeltaW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [RW-1:0]            ring_q, ring_d;
  logic [1:0]               leg_q, leg_d;
  logic                     end_q, end_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [XyW-1:0]           rx_q, rx_d, ry_q, ry_d;
  pick_res_t                res_q, res_d;

  logic [CW-1:0]            px, py;
  logic                     pos_in;
  logic                     hit_now;
  logic signed [DeltaW-1:0] ring_s;
  logic signed [DeltaW-1:0] sdx, sdy;
  logic [RW-1:0]            sring;
  logic [1:0]               sleg;
  logic                     issue;

  assign px = ox_q + {{(CW-DeltaW){dx_q[DeltaW-1]}}, dx_q};
  assign py = oy_q + {{(CW-DeltaW){dy_q[DeltaW-1]}}, dy_q};

  assign pos_in = !px[CW-1] && !py[CW-1] && (px < CW'(SIDE)) && (py < CW'(SIDE));
  assign hit_now = rd_vld_q && (rd_data_i != '0);
  assign issue = (state_q == ST_WALK) && !end_q && !hit_now && pos_in;

  assign rd_addr_o = AW'(py[XW-1:0]) * AW'(SIDE) + AW'(px[XW-1:0]);

  // one spiral step: right, up, left, down
  always_comb begin
    ring_s = $signed({1'b0, ring_q});
    sdx    = dx_q;
    sdy    = dy_q;
    sring  = ring_q;
    sleg   = leg_q;
    case (leg_q)
      2'd0: begin
        sdx = dx_q + 6'sd1;
        if (sdx == ring_s) sleg = 2'd1;
      end
      2'd1: begin
        sdy = dy_q + 6'sd1;
        if (sdy == ring_s) sleg = 2'd2;
      end
      2'd2: begin
        sdx = dx_q - 6'sd1;
        if (-sdx == ring_s) sleg = 2'd3;
      end
      default: begin
        sdy = dy_q - 6'sd1;
        if (-sdy == ring_s) begin
          sleg  = 2'd0;
          sring = ring_q + RW'(1);
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (hit_now || end_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    status_o.busy      = (state_q != ST_IDLE);
    status_o.res_valid = (state_q == ST_DONE);
    rd_en_o            = issue;
  end

  always_comb begin
    ox_d     = ox_q;
    oy_d     = oy_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    ring_d   = ring_q;
    leg_d    = leg_q;
    end_d    = end_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    res_d    = res_q;
    rd_vld_d = 1'b0;
    if (state_q == ST_IDLE && start_i) begin
      ox_d   = {{(CW-OXW){1'b0}}, ox_i};
      oy_d   = {{(CW-OXW){1'b0}}, oy_i};
      dx_d   = '0;
      dy_d   = '0;
      ring_d = RW'(1);
      leg_d  = 2'd0;
      end_d  = 1'b0;
      res_d  = '0;
    end else if (state_q == ST_WALK) begin
      if (hit_now) begin
        res_d.hit = 1'b1;
        res_d.id  = rd_data_i;
        res_d.x   = rx_q;
        res_d.y   = ry_q;
      end else if (!end_q) begin
        rd_vld_d = pos_in;
        rx_d     = px[XyW-1:0];
        ry_d     = py[XyW-1:0];
        dx_d     = sdx;
        dy_d     = sdy;
        ring_d   = sring;
        leg_d    = sleg;
        // limit of zero behaves as one
        end_d    = sring > ((limit_i == '0) ? RW'(1) : {1'b0, limit_i});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      end_q    <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    ring_q <= ring_d;
    leg_q  <= leg_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/spiral_pick_buffer_search_top.sv
// Object-ID pick buffer with spiral neighborhood search.
// Input stream: each beat is either a pixel write (tuser = 0) or a pick
// request (tuser = 1). A write stores one 32-bit ID into the SIDE x SIDE
// image and yields no output beat. A pick converts u,v (16 fraction bits)
// to a start pixel and walks a square spiral around it, ring by ring,
// up to max_ring, returning the first nonzero ID on the output stream.
// Writes are taken one per cycle while no pick is under way. A pick reads the
// image one position per cycle through the single read port of the ID memory;
// no input beat is taken during the walk. A max_ring of 0 counts as 1.
// Output beats sit in a register: while the receiver stalls, writes are
// still accepted, and a following pick finishes its walk and then waits
// until the output register frees up.
// max_ring is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while idle, not enforced by the block. Reset sets max_ring to 2 and clears
// all control state; the image is undefined until written (no clearing pass).
`default_nettype none

module spiral_pick_buffer_search_top #(
  parameter int unsigned SIDE = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // pixel_x, pixel_y, pixel_id, pick_u, pick_v, zero pad
  input  wire logic [79:0] s_axis_tdata_i,
  // operation
  input  wire logic [0:0]  s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // found_id, found_x, found_y, zero pad
  output      logic [47:0] m_axis_tdata_o,
  // hit
  output      logic [0:0]  m_axis_tuser_o,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i
);
  import spb_pkg::*;

  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OXW   = $clog2(SIDE) + 2;
  localparam int unsigned PW    = OXW + 16;

  logic [XyW-1:0]   pixel_x, pixel_y;
  logic [IdW-1:0]   pixel_id;
  logic [16:0]      pick_u, pick_v;
  logic             in_beat;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             pick_start;
  logic [PW-1:0]    prod_u, prod_v;

  logic [RingW-1:0] max_ring_q;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [IdW-1:0]   rd_data;
  ctrl_status_t     status;
  pick_res_t        res;
  logic             res_ready;

  logic             out_vld_q, out_vld_d;
  pick_res_t        out_q;

  assign pixel_x  = s_axis_tdata_i[5:0];
  assign pixel_y  = s_axis_tdata_i[11:6];
  assign pixel_id = s_axis_tdata_i[43:12];
  assign pick_u   = s_axis_tdata_i[60:44];
  assign pick_v   = s_axis_tdata_i[77:61];

  assign s_axis_tready_o = !status.busy;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  assign wr_en = in_beat && (op_e'(s_axis_tuser_i[0]) == OP_WRITE) &&
                 ({3'b000, pixel_x} < 9'(SIDE)) && ({3'b000, pixel_y} < 9'(SIDE));
  assign wr_addr = AW'(pixel_y) * AW'(SIDE) + AW'(pixel_x);

  assign pick_start = in_beat && (op_e'(s_axis_tuser_i[0]) == OP_PICK);
  assign prod_u     = PW'(pick_u) * PW'(SIDE);
  assign prod_v     = PW'(pick_v) * PW'(SIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ring_q <= RingReset;
    end else if (cfg_we_i) begin
      max_ring_q <= cfg_wdata_i;
    end
  end

  spb_id_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (pixel_id),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  spb_search_ctrl #(
    .SIDE (SIDE),
    .OXW  (OXW),
    .AW   (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (pick_start),
    .ox_i        (prod_u[PW-1:16]),
    .oy_i        (prod_v[PW-1:16]),
    .limit_i     (max_ring_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_ready_i (res_ready),
    .status_o    (status),
    .res_o       (res)
  );

  assign res_ready = !out_vld_q || m_axis_tready_i;
  assign out_vld_d = (status.res_valid && res_ready) || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = {4'b0000, out_q.y, out_q.x, out_q.id};
  assign m_axis_tuser_o[0] = out_q.hit;

  a_read_only_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> status.busy)
    else $error("id memory read outside a pick walk");

  a_pick_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_start |=> status.busy)
    else $error("accepted pick did not start a walk");

  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("miss beat carries nonzero data");

  a_no_write_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !wr_en)
    else $error("pixel write during a pick walk");

endmodule

`default_nettype wire

>>> tb/spiral_pick_buffer_search_top_tb.sv
module spiral_pick_buffer_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spb_pkg::*;

  localparam int SIDE = 64;
  localparam int HANG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_BEATS = 320;

  typedef enum logic [1:0] {
    LEG_RIGHT,
    LEG_UP,
    LEG_LEFT,
    LEG_DOWN
  } leg_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [47:0] m_axis_tdata_o;
  wire  [0:0]  m_axis_tuser_o;

  logic [IdW-1:0] image_copy [SIDE*SIDE];
  bit             image_written [SIDE*SIDE];
  logic [3:0]     ring_limit = RingReset;
  int             walk_cells [$];
  pick_res_t      expected_picks [$];

  bit idle_on = 1'b1;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  int stall_cycles = 0;
  int fail_count = 0;
  int beat_count = 0;
  int pick_count = 0;
  int write_count = 0;
  int hit_count = 0;
  int miss_count = 0;

  spiral_pick_buffer_search_top #(
    .SIDE(SIDE)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bit on_image(input int x, input int y);
    return x >= 0 && y >= 0 && x < SIDE && y < SIDE;
  endfunction

  // lists the in-image pixels a pick visits, in spiral order
  function automatic void trace_spiral(input logic [16:0] u, input logic [16:0] v);
    int   ox, oy, dx, dy, ring, lim;
    leg_e leg;
    walk_cells.delete();
    ox = (int'(u) * SIDE) >>> 16;
    oy = (int'(v) * SIDE) >>> 16;
    lim = (ring_limit == 4'd0) ? 1 : int'(ring_limit);
    if (on_image(ox, oy)) walk_cells.insert(walk_cells.size(), oy * SIDE + ox);
    dx = 0;
    dy = 0;
    ring = 1;
    leg = LEG_RIGHT;
    do begin
      case (leg)
        LEG_RIGHT: begin
          dx++;
          if (dx == ring) leg = LEG_UP;
        end
        LEG_UP: begin
          dy++;
          if (dy == ring) leg = LEG_LEFT;
        end
        LEG_LEFT: begin
          dx--;
          if (-dx == ring) leg = LEG_DOWN;
        end
        default: begin
          dy--;
          if (-dy == ring) begin
            leg = LEG_RIGHT;
            ring++;
          end
        end
      endcase
      if (ring <= lim && on_image(ox + dx, oy + dy))
        walk_cells.insert(walk_cells.size(), (oy + dy) * SIDE + ox + dx);
    end while (ring <= lim);
  endfunction

  function automatic pick_res_t first_nonzero_on_walk();
    pick_res_t r;
    r = '0;
    foreach (walk_cells[i]) begin
      if (!r.hit && image_copy[walk_cells[i]] != '0) begin
        r.hit = 1'b1;
        r.id  = image_copy[walk_cells[i]];
        r.x   = XyW'(walk_cells[i] % SIDE);
        r.y   = XyW'(walk_cells[i] / SIDE);
      end
    end
    return r;
  endfunction

  function automatic logic [IdW-1:0] random_id();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] random_coord();
    case ($urandom_range(0, 9))
      0: return 17'd65536;
      1: return 17'($urandom_range(65537, 131071));
      2: return 17'd0;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [79:0] pack_beat(input logic [5:0] x, input logic [5:0] y,
                                            input logic [31:0] id,
                                            input logic [16:0] u, input logic [16:0] v);
    return {2'b00, v, u, id, y, x};
  endfunction

  task automatic send_beat(input op_e op, input logic [79:0] data);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready_o);
    beat_count++;
  endtask

  task automatic send_write(input logic [5:0] x, input logic [5:0] y, input logic [31:0] id);
    image_copy[int'(y) * SIDE + int'(x)] = id;
    image_written[int'(y) * SIDE + int'(x)] = 1'b1;
    write_count++;
    send_beat(OP_WRITE, pack_beat(x, y, id, 17'($urandom), 17'($urandom)));
  endtask

  // unwritten pixels along the walk, up to the first nonzero one, get filled first, nonzero with the given odds
  task automatic send_pick(input logic [16:0] u, input logic [16:0] v, input int nz_pct);
    bit          found;
    int          pos;
    logic [31:0] fill;
    trace_spiral(u, v);
    found = 1'b0;
    for (int i = 0; i < walk_cells.size() && !found; i++) begin
      pos = walk_cells[i];
      if (!image_written[pos]) begin
        fill = '0;
        if ($urandom_range(0, 99) < nz_pct) fill = $urandom | 32'h1;
        send_write(XyW'(pos % SIDE), XyW'(pos / SIDE), fill);
      end
      found = image_copy[pos] != '0;
    end
    expected_picks.insert(expected_picks.size(), first_nonzero_on_walk());
    pick_count++;
    send_beat(OP_PICK, pack_beat(6'($urandom), 6'($urandom), $urandom, u, v));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ring(input logic [3:0] r);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ring_limit = r;
  endtask

  task automatic test_directed();
    send_write(6'd0, 6'd0, 32'hFFFF_FFFF);
    send_write(6'd63, 6'd63, 32'h0000_0001);
    send_pick(17'd0, 17'd0, 0);
    send_pick(17'd65535, 17'd65535, 0);
    // start one past the corner, outside the image
    send_pick(17'd65536, 17'd65536, 0);
    send_pick(17'h1FFFF, 17'h1FFFF, 0);
    send_pick(17'd65536, 17'd0, 0);
    set_ring(4'd0);
    // last corner of the last ring is skipped
    send_write(6'd31, 6'd31, 32'h8000_0000);
    send_pick(17'd32768, 17'd32768, 0);
    send_write(6'd31, 6'd32, 32'h1234_5678);
    send_pick(17'd32768, 17'd32768, 0);
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    set_ring(4'd2);
    rx_hold_req = 400;
    for (int i = 0; i < 48; i++) begin
      if (i % 6 == 3) send_pick(random_coord(), random_coord(), 40);
      else send_write(6'($urandom), 6'($urandom), random_id());
    end
  endtask

  task automatic test_random_traffic();
    logic [3:0] rings [6];
    int         target;
    rings = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd3, 4'd2};
    rings[3] = 4'($urandom_range(1, 15));
    rings[4] = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2) && (ph != 5);
      set_ring(rings[ph]);
      target = beat_count + PHASE_BEATS;
      while (beat_count < target) begin
        if ($urandom_range(0, 99) < 22)
          send_pick(random_coord(), random_coord(), $urandom_range(5, 60));
        else
          send_write(6'($urandom), 6'($urandom), random_id());
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    pick_res_t want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (m_axis_tuser_o[0]) hit_count++;
      else miss_count++;
      if (expected_picks.size() == 0) begin
        $error("result beat with no pick outstanding");
        fail_count++;
      end else begin
        want = expected_picks.pop_front();
        if (m_axis_tuser_o[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser_o[0]);
          fail_count++;
        end
        if (m_axis_tdata_o[IdW-1:0] !== want.id) begin
          $error("found_id: expected %h, got %h", want.id, m_axis_tdata_o[IdW-1:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[IdW +: XyW] !== want.x) begin
          $error("found_x: expected %0d, got %0d", want.x, m_axis_tdata_o[IdW +: XyW]);
          fail_count++;
        end
        if (m_axis_tdata_o[IdW+XyW +: XyW] !== want.y) begin
          $error("found_y: expected %0d, got %0d", want.y, m_axis_tdata_o[IdW+XyW +: XyW]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HANG_LIMIT) begin
      $display("no beat moved for %0d cycles", HANG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_stall();
    test_random_traffic();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d beats in: %0d pixel writes, %0d picks (%0d hits, %0d misses)",
             beat_count, write_count, pick_count, hit_count, miss_count);
    $display("ring limits 0, 1, 2, 15 and random, off-image starts, long output stall");
    if (fail_count == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> spiral_pick_buffer_search_top.f
rtl/spb_pkg.sv
rtl/spb_id_ram.sv
rtl/spb_search_ctrl.sv
rtl/spiral_pick_buffer_search_top.sv
tb/spiral_pick_buffer_search_top_tb.sv
